// ----- hdl/seven_segment_mux_display_unit_macros.svh -----
// Assertion macros shared by the seven-segment display unit modules.
// No dependencies; define SYNTH to compile the checks away.
`ifndef SEVEN_SEGMENT_MUX_DISPLAY_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_MUX_DISPLAY_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/ssm_pkg.sv -----
// Types, constants and the segment decoder of the seven-segment display unit.
// No dependencies.
package ssm_pkg;

    localparam int SSM_DIGITS = 3;

    localparam logic [7:0]  SLOT_TICKS_RESET    = 8'd5;
    localparam logic [15:0] DISPLAY_TICKS_RESET = 16'd1000;
    localparam logic [7:0]  SEGMENT_RESET       = 8'hFF;
    localparam logic [16:0] ELAPSED_MAX         = 17'h1FFFF;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [15:0] RECIP10       = 16'hCCCD;
    localparam int          RECIP10_SHIFT = 19;

    localparam logic REG_SLOT_TICKS    = 1'b0;
    localparam logic REG_DISPLAY_TICKS = 1'b1;

    localparam logic FUNC_LOAD = 1'b0;

    typedef struct packed {
        logic        func;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] segments;
        logic [2:0] digit_enable;
        logic       active;
    } t_out_item;

    // common-cathode pattern, digit taken mod 10
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0, 4'd10: pat = 8'h3F;
            4'd1, 4'd11: pat = 8'h06;
            4'd2, 4'd12: pat = 8'h5B;
            4'd3, 4'd13: pat = 8'h4F;
            4'd4, 4'd14: pat = 8'h66;
            4'd5, 4'd15: pat = 8'h6D;
            4'd6:        pat = 8'h7D;
            4'd7:        pat = 8'h07;
            4'd8:        pat = 8'h7F;
            4'd9:        pat = 8'h6F;
            default:     pat = 8'h3F;
        endcase
        return pat;
    endfunction

endpackage

// ----- hdl/ssm_front.sv -----
// Front end: accepts requests and splits the load value into decimal digits,
// one digit per pipeline stage. Depends on ssm_pkg.
module ssm_front import ssm_pkg::*; #(
    parameter int DIGITS = SSM_DIGITS,
    parameter int QDEPTH = SSM_DIGITS + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_in_item            i_item,
    output logic                o_full,
    input  logic                i_release,
    output logic                o_work_valid,
    output logic [4*DIGITS:0]   o_work
);

    localparam int CW = $clog2(QDEPTH + 1);

    logic              s_vld  [DIGITS];
    logic              s_func [DIGITS];
    logic [15:0]       s_quo  [DIGITS];
    logic [4*DIGITS-1:0] s_dig [DIGITS];

    logic              r_vld  [DIGITS];
    logic              r_func [DIGITS];
    logic [15:0]       r_quo  [DIGITS];
    logic [4*DIGITS-1:0] r_dig [DIGITS];

    logic [CW-1:0]     r_cnt, n_cnt;
    logic              accept;

    assign o_full = (r_cnt == CW'(QDEPTH));
    assign accept = i_push && !o_full;

    // requests in flight plus those waiting in the queue
    always_comb begin
        n_cnt = r_cnt;
        if (accept && !i_release) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!accept && i_release) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        s_vld[0]  = accept;
        s_func[0] = i_item.func;
        s_quo[0]  = i_item.value;
        s_dig[0]  = '0;
        for (int k = 1; k < DIGITS; k++) begin
            s_vld[k]  = r_vld[k-1];
            s_func[k] = r_func[k-1];
            s_quo[k]  = r_quo[k-1];
            s_dig[k]  = r_dig[k-1];
        end
    end

    for (genvar k = 0; k < DIGITS; k++) begin : g_stage
        logic [31:0]         prod;
        logic [15:0]         quo;
        logic [15:0]         quo_x10;
        logic [3:0]          dig;
        logic [4*DIGITS-1:0] n_dig;

        always_comb begin
            prod    = 32'(s_quo[k]) * 32'(RECIP10);
            quo     = 16'(prod >> RECIP10_SHIFT);
            quo_x10 = 16'(quo << 3) + 16'(quo << 1);
            dig     = 4'(s_quo[k] - quo_x10);
            n_dig   = s_dig[k];
            n_dig[4*k +: 4] = dig;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_func[k] <= s_func[k];
            r_quo[k]  <= quo;
            r_dig[k]  <= n_dig;
        end
    end

    assign o_work_valid = r_vld[DIGITS-1];
    assign o_work       = {r_func[DIGITS-1], r_dig[DIGITS-1]};

endmodule

// ----- hdl/ssm_queue.sv -----
// Short flop-based queue between the front end and the display sequencer.
// Depends on ssm_pkg and the assertion macros.
`include "seven_segment_mux_display_unit_macros.svh"
module ssm_queue import ssm_pkg::*; #(
    parameter int WIDTH = 4 * SSM_DIGITS + 1,
    parameter int DEPTH = SSM_DIGITS + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // the front end's credit count must keep the queue from overflowing
    `SSM_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, r_count != CW'(DEPTH))
    `SSM_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `SSM_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !i_push && !i_pop, $stable(r_count))

endmodule

// ----- hdl/ssm_back.sv -----
// Display sequencer: runs the slot and pass counters, picks the lit digit
// and holds the result register. Depends on ssm_pkg and the assertion macros.
`include "seven_segment_mux_display_unit_macros.svh"
module ssm_back import ssm_pkg::*; #(
    parameter int DIGITS = SSM_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_slot_ticks,
    input  logic [15:0]       i_display_ticks,
    input  logic              i_work_valid,
    input  logic [4*DIGITS:0] i_work,
    output logic              o_take,
    input  logic              i_pop,
    output logic              o_empty,
    output t_out_item         o_item
);

    localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [3:0]  r_digits [DIGITS];
    logic [3:0]  n_digits [DIGITS];
    logic [IW-1:0] r_index, n_index;
    logic [7:0]  r_slot, n_slot;
    logic [16:0] r_elapsed, n_elapsed;
    logic        r_running, n_running;
    logic [7:0]  r_seg, n_seg;

    t_out_item   r_out;
    logic        r_out_valid;

    logic        fire;
    logic        w_func;
    logic [4*DIGITS-1:0] w_dig;
    logic [7:0]  slot_len;
    logic [7:0]  slot_inc;
    logic [10:0] pass_ticks;
    logic [17:0] elapsed_sum;
    logic [2:0]  enable;

    assign fire   = i_work_valid && (!r_out_valid || i_pop);
    assign o_take = fire;
    assign w_func = i_work[4*DIGITS];
    assign w_dig  = i_work[4*DIGITS-1:0];

    always_comb begin
        n_digits    = r_digits;
        n_index     = r_index;
        n_slot      = r_slot;
        n_elapsed   = r_elapsed;
        n_running   = r_running;
        n_seg       = r_seg;
        slot_len    = (i_slot_ticks == 8'd0) ? 8'd1 : i_slot_ticks;
        slot_inc    = r_slot + 8'd1;
        pass_ticks  = 11'(DIGITS) * 11'(slot_len);
        elapsed_sum = 18'(r_elapsed) + 18'(pass_ticks);
        if (w_func == FUNC_LOAD) begin
            for (int k = 0; k < DIGITS; k++) begin
                n_digits[k] = w_dig[4*k +: 4];
            end
            n_index   = '0;
            n_slot    = '0;
            n_elapsed = '0;
            n_running = (i_display_ticks != 16'd0);
            n_seg     = seg_pattern(w_dig[3:0]);
        end else if (r_running) begin
            if (slot_inc >= slot_len) begin
                n_slot = '0;
                if (r_index == IW'(DIGITS - 1)) begin
                    // pass complete: account time, saturating, then test end
                    n_index   = '0;
                    n_elapsed = (elapsed_sum > 18'(ELAPSED_MAX)) ? ELAPSED_MAX
                                                                 : elapsed_sum[16:0];
                    if (n_elapsed >= 17'(i_display_ticks)) begin
                        n_running = 1'b0;
                    end
                end else begin
                    n_index = r_index + IW'(1);
                end
                if (n_running) begin
                    n_seg = seg_pattern(r_digits[n_index]);
                end
            end else begin
                n_slot = slot_inc;
            end
        end
    end

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            enable[b] = (b < DIGITS) && n_running && (n_index == IW'(b));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIGITS; k++) begin
                r_digits[k] <= '0;
            end
            r_index     <= '0;
            r_slot      <= '0;
            r_elapsed   <= '0;
            r_running   <= 1'b0;
            r_seg       <= SEGMENT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_digits    <= n_digits;
                r_index     <= n_index;
                r_slot      <= n_slot;
                r_elapsed   <= n_elapsed;
                r_running   <= n_running;
                r_seg       <= n_seg;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.segments     <= n_seg;
            r_out.digit_enable <= enable;
            r_out.active       <= n_running;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    `SSM_ASSERT_IMPLY(a_enable_onehot, i_clk, i_rst_n, r_out_valid, $onehot0(r_out.digit_enable))
    `SSM_ASSERT_IMPLY(a_idle_dark, i_clk, i_rst_n, r_out_valid && !r_out.active, r_out.digit_enable == 3'b000)
    `SSM_ASSERT_IMPLY(a_index_range, i_clk, i_rst_n, 1'b1, r_index <= IW'(DIGITS - 1))
    `SSM_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_pop, !o_take)

endmodule

// ----- hdl/seven_segment_mux_display_unit.sv -----
// A request accepted at one edge passes the front-end divider pipeline, the queue
// and the display sequencer's result register. Throughput: one request per cycle
// while results are popped; a queue of DIGITS+2 entries absorbs stalls.
// Reset (synchronous, active low): idle, all digits 0, segments 0xFF,
// slot_ticks 5, display_ticks 1000, no results pending.
module seven_segment_mux_display_unit import ssm_pkg::*; #(
    parameter int DIGITS = SSM_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QDEPTH = DIGITS + 2;
    localparam int QW     = 4 * DIGITS + 1;

    logic [7:0]    r_slot_ticks;
    logic [15:0]   r_display_ticks;
    logic          cfg_write;

    logic          work_valid;
    logic [QW-1:0] work;
    logic          q_valid;
    logic [QW-1:0] q_data;
    logic          q_take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ticks    <= SLOT_TICKS_RESET;
            r_display_ticks <= DISPLAY_TICKS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_SLOT_TICKS:    r_slot_ticks    <= pwdata[7:0];
                REG_DISPLAY_TICKS: r_display_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SLOT_TICKS:    prdata = {24'd0, r_slot_ticks};
            REG_DISPLAY_TICKS: prdata = {16'd0, r_display_ticks};
            default:           prdata = '0;
        endcase
    end

    ssm_front #(
        .DIGITS (DIGITS),
        .QDEPTH (QDEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_in_item),
        .o_full       (full),
        .i_release    (q_take),
        .o_work_valid (work_valid),
        .o_work       (work)
    );

    ssm_queue #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_valid),
        .i_data  (work),
        .i_pop   (q_take),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    ssm_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slot_ticks    (r_slot_ticks),
        .i_display_ticks (r_display_ticks),
        .i_work_valid    (q_valid),
        .i_work          (q_data),
        .o_take          (q_take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_item          (o_out_item)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the multiplexed seven-segment display unit: a directed table of loads, ticks
// and register writes, then random load/tick traffic with stalls on both queue sides.
// Depends on ssm_pkg and seven_segment_mux_display_unit; results checked by a local predictor.
module tb_top;
    import ssm_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 10;
    localparam int MAX_WAIT    = 14;
    localparam int SETTLE      = SSM_DIGITS + 3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int RAND_ITEMS  = 1425;
    localparam int PHASES      = 10;

    localparam logic FUNC_TICK = 1'b1;

    // digit 9 down to digit 0, one byte each
    localparam logic [79:0] SEG_LUT = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                       8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_in_item    item;
        bit          typed;
        t_out_item   want;
        logic        reg_sel;
        logic [15:0] reg_val;
    } t_dir_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        pop     = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    t_in_item    req_item = '0;
    logic        full;
    logic        empty;
    t_out_item   shown_item;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and its copy of the registers
    logic [7:0]  cfg_slot;
    logic [15:0] cfg_disp;
    logic [3:0]  dig_val [SSM_DIGITS];
    logic [1:0]  dig_pos;
    logic [7:0]  slot_cnt;
    logic [16:0] elapsed_cnt;
    logic        run_on;
    logic [7:0]  seg_hold;

    t_out_item   display_q [$];
    t_out_item   want_item;
    t_dir_row    dir_rows [$];
    int          fail_cnt  = 0;
    int          stall_cnt = 0;
    int          rx_hold   = 0;
    bit          tx_calm   = 1'b0;
    bit          rx_calm   = 1'b0;

    seven_segment_mux_display_unit u_top (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_in_item  (req_item),
        .empty,
        .pop,
        .o_out_item (shown_item),
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic void report_diff(string what, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            fail_cnt++;
            $display("%0t %s: expected %h, got %h", $time, what, want_v, got_v);
        end
    endfunction

    function automatic void display_reset();
        int k;
        cfg_slot    = SLOT_TICKS_RESET;
        cfg_disp    = DISPLAY_TICKS_RESET;
        for (k = 0; k < SSM_DIGITS; k++)
            dig_val[k] = '0;
        dig_pos     = '0;
        slot_cnt    = '0;
        elapsed_cnt = '0;
        run_on      = 1'b0;
        seg_hold    = SEGMENT_RESET;
    endfunction

    // advances the display state by one request and returns the shown outputs
    function automatic t_out_item display_predict(input t_in_item it);
        int unsigned slot_len;
        int unsigned v;
        int unsigned sum;
        int          k;
        t_out_item   r;
        slot_len = (cfg_slot == 8'd0) ? 1 : cfg_slot;
        if (it.func == FUNC_LOAD) begin
            v = it.value;
            for (k = 0; k < SSM_DIGITS; k++) begin
                dig_val[k] = 4'(v % 10);
                v = v / 10;
            end
            dig_pos     = '0;
            slot_cnt    = '0;
            elapsed_cnt = '0;
            run_on      = (cfg_disp != 16'd0);
            seg_hold    = SEG_LUT[8*dig_val[0] +: 8];
        end else if (run_on) begin
            slot_cnt = slot_cnt + 8'd1;
            if (slot_cnt >= slot_len) begin
                slot_cnt = '0;
                if (dig_pos == 2'(SSM_DIGITS - 1)) begin
                    dig_pos = '0;
                    sum = elapsed_cnt + SSM_DIGITS * slot_len;
                    elapsed_cnt = (sum > ELAPSED_MAX) ? ELAPSED_MAX : 17'(sum);
                    if (elapsed_cnt >= cfg_disp)
                        run_on = 1'b0;
                end else begin
                    dig_pos = dig_pos + 2'd1;
                end
                if (run_on)
                    seg_hold = SEG_LUT[8*dig_val[dig_pos] +: 8];
            end
        end
        r.segments     = seg_hold;
        r.digit_enable = run_on ? (3'b001 << dig_pos) : 3'b000;
        r.active       = run_on;
        return r;
    endfunction

    function automatic void row_item(logic func, logic [15:0] value);
        t_dir_row row;
        row.kind       = ROW_ITEM;
        row.item.func  = func;
        row.item.value = value;
        row.typed      = 1'b0;
        row.want       = '0;
        row.reg_sel    = REG_SLOT_TICKS;
        row.reg_val    = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_known(logic func, logic [15:0] value, logic [7:0] seg,
                                      logic [2:0] en, logic act);
        row_item(func, value);
        dir_rows[$].typed = 1'b1;
        dir_rows[$].want  = '{segments: seg, digit_enable: en, active: act};
    endfunction

    function automatic void row_reg(logic sel, logic [15:0] val);
        row_item(FUNC_TICK, '0);
        dir_rows[$].kind    = ROW_REG;
        dir_rows[$].reg_sel = sel;
        dir_rows[$].reg_val = val;
    endfunction

    task automatic send_request(input t_in_item it, input bit typed, input t_out_item typed_want);
        int        gap;
        t_out_item got;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        req_item <= it;
        do @(posedge i_clk); while (full);
        got = display_predict(it);
        display_q.push_back(typed ? typed_want : got);
    endtask

    // sender stops until every result is back, then lets the pipeline settle
    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (display_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write_check(input logic sel, input logic [15:0] val);
        logic [31:0] want_v;
        want_v = (sel == REG_SLOT_TICKS) ? {24'b0, val[7:0]} : {16'b0, val};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= want_v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == REG_SLOT_TICKS)
            cfg_slot = val[7:0];
        else
            cfg_disp = val;
        // read back the same register
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        report_diff("register readback", want_v, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (display_q.size() == 0) begin
                fail_cnt++;
                $display("%0t unexpected result: expected none, got %h", $time, shown_item);
            end else begin
                want_item = display_q.pop_front();
                report_diff("segments", want_item.segments, shown_item.segments);
                report_diff("digit_enable", want_item.digit_enable, shown_item.digit_enable);
                report_diff("active", want_item.active, shown_item.active);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || psel) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin : rx_proc
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                hold    = rx_hold;
                rx_hold = 0;
                pop <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            hold = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0) begin
                pop <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin : tx_proc
        t_in_item    it;
        t_out_item   none;
        int          sent;
        int          p;
        logic [7:0]  slot_v;
        logic [15:0] disp_v;
        none = '0;
        display_reset();

        row_known(FUNC_TICK, 16'h0000, SEGMENT_RESET, 3'b000, 1'b0);  // idle after reset
        row_known(FUNC_LOAD, 16'd0,     8'h3F, 3'b001, 1'b1);
        row_known(FUNC_LOAD, 16'hFFFF,  8'h6D, 3'b001, 1'b1);
        row_known(FUNC_LOAD, 16'd999,   8'h6F, 3'b001, 1'b1);
        repeat (5) row_item(FUNC_TICK, 16'hFFFF);
        row_reg(REG_SLOT_TICKS, 16'd1);
        repeat (3) row_item(FUNC_TICK, 16'h5A5A);
        row_reg(REG_SLOT_TICKS, 16'd0);                              // zero slot acts as one
        repeat (2) row_item(FUNC_TICK, 16'hA5A5);
        row_reg(REG_DISPLAY_TICKS, 16'd0);                           // zero display time
        row_known(FUNC_LOAD, 16'd905,   8'h6D, 3'b000, 1'b0);
        row_known(FUNC_TICK, 16'h0000,  8'h6D, 3'b000, 1'b0);
        row_reg(REG_DISPLAY_TICKS, 16'd3);
        row_reg(REG_SLOT_TICKS, 16'd1);
        row_known(FUNC_LOAD, 16'd321,   8'h06, 3'b001, 1'b1);
        repeat (4) row_item(FUNC_TICK, 16'h0001);                    // run ends after one pass
        row_reg(REG_SLOT_TICKS, 16'd255);
        row_reg(REG_DISPLAY_TICKS, 16'hFFFF);
        row_item(FUNC_LOAD, 16'hFFFF);
        repeat (2) row_item(FUNC_TICK, 16'h8000);
        row_reg(REG_SLOT_TICKS, 16'd1);                              // lowered below slot count
        row_item(FUNC_TICK, 16'h7FFF);

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG) begin
                wait_idle();
                reg_write_check(dir_rows[r].reg_sel, dir_rows[r].reg_val);
            end else begin
                send_request(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       begin slot_v = 8'd1;   disp_v = 16'd1;     end
                1:       begin slot_v = 8'd255; disp_v = 16'hFFFF;  end
                2:       begin slot_v = 8'd0;   disp_v = 16'd9;     end
                3:       begin slot_v = 8'd2;   disp_v = 16'd0;     end
                4:       begin slot_v = 8'd3;   disp_v = 16'hFFFF;  end
                default: begin
                    slot_v = 8'($urandom_range(0, 6));
                    disp_v = 16'($urandom_range(0, 48));
                end
            endcase
            reg_write_check(REG_SLOT_TICKS, {8'b0, slot_v});
            reg_write_check(REG_DISPLAY_TICKS, disp_v);
            tx_calm = (p % 3 == 0);
            rx_calm = (p % 4 == 1);
            sent = 0;
            while (sent < RAND_ITEMS / PHASES) begin
                // receiver holds off while requests keep coming, so the queue fills
                if (p == 0 && sent == 30)
                    rx_hold = HOLD_CYCLES;
                if (p == 5 && sent == 60)
                    wait_idle();
                it.func  = ($urandom_range(0, run_on ? 15 : 1) == 0) ? FUNC_LOAD : FUNC_TICK;
                it.value = 16'($urandom());
                sent++;
                send_request(it, 1'b0, none);
            end
        end

        wait_idle();
        if (fail_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
